### hw/rtl/vpf_pkg.sv
// shared types and constants of the voice packet framer
// no dependencies; imported by every module of the block
`default_nettype none

package vpf_pkg;

   // bytes a start beat can produce: header, two sequence bytes, two length bytes
   localparam int unsigned MAX_BYTES = 5;
   localparam int unsigned CNT_W     = 3;

   // status codes of a result beat
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SEQ   = 3'd1;
   localparam logic [2:0] ST_LEN   = 3'd2;
   localparam logic [2:0] ST_STRAY = 3'd3;
   localparam logic [2:0] ST_OPEN  = 3'd4;

   // item kinds
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // varint continuation flag
   localparam logic [7:0] VARINT_FLAG = 8'h80;

   typedef struct packed {
      logic        kind;
      logic [2:0]  pkt_type;
      logic [4:0]  target;
      logic [15:0] sequence_req;
      logic [15:0] frame_length;
      logic [7:0]  payload_byte;
   } vpf_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [2:0] status;
   } vpf_rsp_type;

   // classified work for the back end; byte 0 sits in the low bits
   typedef struct packed {
      logic [MAX_BYTES*8-1:0] bytes;
      logic [CNT_W-1:0]       nbytes;
      logic                   last;
      logic [2:0]             status;
   } vpf_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/vpf_front.sv
// front end: checks each request beat, tracks the open packet, builds commands
// depends on vpf_pkg
`default_nettype none

module vpf_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   input  vpf_pkg::vpf_req_type req_data,
   input  wire                 q_full,
   output logic                cmd_push,
   output vpf_pkg::vpf_cmd_type cmd
);
   import vpf_pkg::*;

   logic        open_ff, open_in;
   logic [12:0] remain_ff, remain_in;

   logic [7:0]  hdr, seq_hi, len_hi;
   logic        seq_long, len_long;
   logic [12:0] remain_dec;
   logic        seq_bad, len_bad;

   assign cmd_push   = req_push && !q_full;
   assign hdr        = {req_data.pkt_type, req_data.target};
   assign seq_long   = |req_data.sequence_req[13:7];
   assign len_long   = |req_data.frame_length[12:7];
   assign seq_hi     = VARINT_FLAG | {2'b00, req_data.sequence_req[13:8]};
   assign len_hi     = VARINT_FLAG | {3'b000, req_data.frame_length[12:8]};
   assign remain_dec = remain_ff - 13'd1;
   assign seq_bad    = |req_data.sequence_req[15:14];
   assign len_bad    = (req_data.frame_length == 16'd0) || (|req_data.frame_length[15:13]);

   always_comb begin
      open_in    = open_ff;
      remain_in  = remain_ff;
      cmd.bytes  = '0;
      cmd.nbytes = CNT_W'(1);
      cmd.last   = 1'b1;
      cmd.status = ST_OK;

      if (req_data.kind == KIND_START) begin
         if (open_ff) begin
            cmd.status = ST_OPEN;
         end else if (seq_bad) begin
            cmd.status = ST_SEQ;
         end else if (len_bad) begin
            cmd.status = ST_LEN;
         end else begin
            cmd.last   = 1'b0;
            cmd.nbytes = CNT_W'(3) + CNT_W'(seq_long) + CNT_W'(len_long);
            unique case ({seq_long, len_long})
               2'b00: cmd.bytes = {16'h0000, req_data.frame_length[7:0],
                                   req_data.sequence_req[7:0], hdr};
               2'b01: cmd.bytes = {8'h00, req_data.frame_length[7:0], len_hi,
                                   req_data.sequence_req[7:0], hdr};
               2'b10: cmd.bytes = {8'h00, req_data.frame_length[7:0],
                                   req_data.sequence_req[7:0], seq_hi, hdr};
               2'b11: cmd.bytes = {req_data.frame_length[7:0], len_hi,
                                   req_data.sequence_req[7:0], seq_hi, hdr};
               default: cmd.bytes = '0;
            endcase
            open_in   = 1'b1;
            remain_in = req_data.frame_length[12:0];
         end
      end else begin
         if (!open_ff) begin
            cmd.status = ST_STRAY;
         end else begin
            cmd.bytes  = {{(MAX_BYTES*8-8){1'b0}}, req_data.payload_byte};
            remain_in  = remain_dec;
            cmd.last   = (remain_dec == 13'd0);
            open_in    = (remain_dec != 13'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         remain_ff <= '0;
      end else if (cmd_push) begin
         open_ff   <= open_in;
         remain_ff <= remain_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vpf_queue.sv
// command queue between front and back end
// depends on vpf_pkg
`default_nettype none

module vpf_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  vpf_pkg::vpf_cmd_type push_data,
   output logic                 full,
   input  wire                  pop,
   output vpf_pkg::vpf_cmd_type head,
   output logic                 empty
);
   import vpf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

   vpf_cmd_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W_Q-1:0] count_ff;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W_Q'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W_Q'(do_push) - CNT_W_Q'(do_pop);
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vpf_back.sv
// back end: serializes commands into response beats through an output register
// depends on vpf_pkg
`default_nettype none

module vpf_back (
   input  wire                  clock,
   input  wire                  reset,
   input  vpf_pkg::vpf_cmd_type head,
   input  wire                  q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output vpf_pkg::vpf_rsp_type rsp_data
);
   import vpf_pkg::*;

   logic [MAX_BYTES*8-1:0] cur_bytes_ff, cur_bytes_in;
   logic [CNT_W-1:0]       cur_cnt_ff, cur_cnt_in;
   logic                   out_valid_ff, out_valid_in;
   vpf_rsp_type            out_ff, out_in;
   logic                   slot_open;

   assign slot_open = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      cur_bytes_in = cur_bytes_ff;
      cur_cnt_in   = cur_cnt_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      q_pop        = 1'b0;
      if (slot_open) begin
         if (cur_cnt_ff != '0) begin
            // remaining header bytes of a start command
            out_valid_in    = 1'b1;
            out_in.out_byte = cur_bytes_ff[7:0];
            out_in.last     = 1'b0;
            out_in.status   = ST_OK;
            cur_bytes_in    = cur_bytes_ff >> 8;
            cur_cnt_in      = cur_cnt_ff - CNT_W'(1);
         end else if (!q_empty) begin
            q_pop           = 1'b1;
            out_valid_in    = 1'b1;
            out_in.out_byte = head.bytes[7:0];
            out_in.last     = head.last;
            out_in.status   = head.status;
            cur_bytes_in    = head.bytes >> 8;
            cur_cnt_in      = head.nbytes - CNT_W'(1);
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_cnt_ff   <= cur_cnt_in;
         out_valid_ff <= out_valid_in;
         cur_bytes_ff <= cur_bytes_in;
         out_ff       <= out_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/voice_packet_framer.sv
// top level of the voice packet framer
// depends on vpf_pkg, vpf_front, vpf_queue and vpf_back
`default_nettype none

// Voice packet framer. Request beats are either a start (codec type, target,
// sequence, length) or one payload byte; response beats are the bytes of the
// framed packet: a header byte {type, target}, a short varint of the
// sequence, a short varint of the length, then the payload bytes, the final
// one flagged last. A bad start (packet already open, sequence 0x4000 or
// more, length 0 or 0x2000 or more) or a payload beat with no open packet
// yields a single error beat with byte zero, last set and the status code.
// The front end checks each beat and updates the packet state in the cycle
// it is accepted, so it takes one request beat per clock as long as the
// command queue (QUEUE_DEPTH entries) has room. The back end emits one
// response beat per clock through its output register while rsp_pop drains
// it: payload and error commands give one beat, a start gives three to five
// beats (one per header byte), and that back-end serializer is what sets
// the sustained rate when starts are frequent. With nothing queued, a request
// passes the command queue and then the output register before its first beat.
module voice_packet_framer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  vpf_pkg::vpf_req_type req_data,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output vpf_pkg::vpf_rsp_type rsp_data
);
   import vpf_pkg::*;

   // front to queue
   logic        cmd_push;
   vpf_cmd_type cmd;

   // queue to back end
   logic        q_full, q_empty, q_pop;
   vpf_cmd_type q_head;

   assign req_full = q_full;

   vpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   vpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   vpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // an error command is always a single zero beat marked last
   a_err_cmd_shape: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd.status != ST_OK) |->
         (cmd.last && cmd.nbytes == CNT_W'(1) && cmd.bytes == '0))
      else $error("error command with bad shape");

   // multi-byte commands are headers: ok status, never last
   a_hdr_cmd_shape: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd.nbytes != CNT_W'(1)) |->
         (cmd.status == ST_OK && !cmd.last &&
          (cmd.nbytes == CNT_W'(3) || cmd.nbytes == CNT_W'(4) ||
           cmd.nbytes == CNT_W'(5))))
      else $error("header command with bad length or flags");

   // back end never pops an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // an error beat on the response side carries a zero byte and last
   a_err_rsp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_OK) |->
         (rsp_data.out_byte == 8'h00 && rsp_data.last))
      else $error("error beat with data or without last");

endmodule

`default_nettype wire
